// ===== design/idl_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the indexed deque list
package idl_pkg;

    // fixed widths of the port fields
    localparam int CMD_W   = 3;
    localparam int PORT_W  = 32;
    localparam int POS_W   = 8;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 9;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD_BACK  = 3'd0,
        CMD_ADD_FRONT = 3'd1,
        CMD_POP_FIRST = 3'd2,
        CMD_POP_LAST  = 3'd3,
        CMD_GET       = 3'd4,
        CMD_REMOVE    = 3'd5
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

endpackage

// ===== design/idl_mem.sv =====
`timescale 1ns / 1ps
// entry store: one write port, one read port with registered read data
module idl_mem #(
    parameter int DEPTH  = 256,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/indexed_deque_list.sv =====
`timescale 1ns / 1ps
// indexed deque list top level: command sequencer around the entry store
//
// keeps an ordered list of up to CAPACITY words, contiguous from position 0,
// and runs one command per start: add back, add front, pop first, pop last,
// get by position, remove by position. a command is taken when start is high
// and busy is low; busy then stays high until the result word comes out on
// the o_ ports together with a one-cycle o_done strobe, which the receiver
// must take in that cycle. a new start may be given in the o_done cycle.
// every result carries the count and the first and last entries after the
// command. all entry movement goes through one store with a single read
// port and a single write port, so the shift loop moves one entry per cycle.
// the time to o_done grows with the entries moved: add front shifts every
// entry up, pop first and remove shift the entries above the position down.
// a command that leaves the list empty, or meets an empty list, skips the
// read of the first and last entries and so ends sooner. the longest
// commands are pop first and remove at position 0 on a full list.
// the store needs no clearing pass after reset: only positions below the
// count are ever read.
module indexed_deque_list #(
    parameter int CAPACITY   = 256,
    parameter int WORD_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    input  logic [idl_pkg::CMD_W-1:0]   i_command,
    input  logic [idl_pkg::PORT_W-1:0]  i_entry_value,
    input  logic [idl_pkg::POS_W-1:0]   i_position,
    output logic                        busy,
    output logic                        o_done,
    output logic [idl_pkg::PORT_W-1:0]  o_result_value,
    output logic                        o_found,
    output logic [idl_pkg::STAT_W-1:0]  o_status,
    output logic [idl_pkg::COUNT_W-1:0] o_entry_count,
    output logic [idl_pkg::PORT_W-1:0]  o_first_value,
    output logic [idl_pkg::PORT_W-1:0]  o_last_value
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > idl_pkg::POS_W) ? CNT_W : idl_pkg::POS_W;

    // one-hot sequencer states
    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_FETCH = 8'b0000_0010,  // read the addressed entry
        S_GRAB  = 8'b0000_0100,  // capture it, set up the shift
        S_SHIFT = 8'b0000_1000,  // move one entry per cycle
        S_FRONT = 8'b0001_0000,  // drop the new word into position 0
        S_PEEK0 = 8'b0010_0000,  // read the first entry
        S_PEEK1 = 8'b0100_0000,  // capture first, read the last entry
        S_PEEK2 = 8'b1000_0000   // capture last, emit the result word
    } t_state;

    t_state             r_state, n_state;
    idl_pkg::t_cmd      r_cmd, n_cmd;
    logic [WORD_WIDTH-1:0] r_word, n_word;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [ADDR_W-1:0]  r_pos, n_pos;
    // shift unit: read address, address of the pending read, reads left
    logic [ADDR_W-1:0]  r_src, n_src;
    logic [ADDR_W-1:0]  r_dst, n_dst;
    logic [CNT_W-1:0]   r_left, n_left;
    logic               r_pend, n_pend;
    logic               r_up, n_up;
    // result being built
    logic [WORD_WIDTH-1:0] r_val, n_val;
    logic               r_found, n_found;
    idl_pkg::t_status   r_status, n_status;
    logic [WORD_WIDTH-1:0] r_first, n_first;
    // output word
    logic               r_done, n_done;
    logic [idl_pkg::PORT_W-1:0]  r_o_val, n_o_val;
    logic               r_o_found, n_o_found;
    idl_pkg::t_status   r_o_status, n_o_status;
    logic [idl_pkg::COUNT_W-1:0] r_o_count, n_o_count;
    logic [idl_pkg::PORT_W-1:0]  r_o_first, n_o_first;
    logic [idl_pkg::PORT_W-1:0]  r_o_last, n_o_last;

    // store port
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [WORD_WIDTH-1:0] mem_wdata;
    logic                  mem_re;
    logic [ADDR_W-1:0]     mem_raddr;
    logic [WORD_WIDTH-1:0] mem_rdata;

    logic             full;
    logic             empty;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic [ADDR_W-1:0] last_addr;

    idl_mem #(
        .DEPTH  (CAPACITY),
        .WIDTH  (WORD_WIDTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign full      = (r_count == CNT_W'(CAPACITY));
    assign empty     = (r_count == '0);
    assign pos_ext   = CMP_W'(i_position);
    assign cnt_ext   = CMP_W'(r_count);
    assign last_addr = ADDR_W'(r_count - CNT_W'(1));

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_word     = r_word;
        n_count    = r_count;
        n_pos      = r_pos;
        n_src      = r_src;
        n_dst      = r_dst;
        n_left     = r_left;
        n_pend     = r_pend;
        n_up       = r_up;
        n_val      = r_val;
        n_found    = r_found;
        n_status   = r_status;
        n_first    = r_first;
        n_done     = 1'b0;
        n_o_val    = r_o_val;
        n_o_found  = r_o_found;
        n_o_status = r_o_status;
        n_o_count  = r_o_count;
        n_o_first  = r_o_first;
        n_o_last   = r_o_last;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = '0;
        mem_re     = 1'b0;
        mem_raddr  = '0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd    = idl_pkg::t_cmd'(i_command);
                    n_word   = WORD_WIDTH'(i_entry_value);
                    n_pos    = ADDR_W'(i_position);
                    n_val    = '0;
                    n_found  = 1'b0;
                    n_status = idl_pkg::ST_OK;
                    n_state  = S_PEEK0;
                    unique case (idl_pkg::t_cmd'(i_command))
                        idl_pkg::CMD_ADD_BACK: begin
                            if (full) begin
                                n_status = idl_pkg::ST_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = ADDR_W'(r_count);
                                mem_wdata = WORD_WIDTH'(i_entry_value);
                                n_count   = r_count + CNT_W'(1);
                            end
                        end
                        idl_pkg::CMD_ADD_FRONT: begin
                            if (full) begin
                                n_status = idl_pkg::ST_FULL;
                            end else begin
                                // shift up from the last entry toward position 0
                                n_src   = last_addr;
                                n_left  = r_count;
                                n_up    = 1'b1;
                                n_pend  = 1'b0;
                                n_state = S_SHIFT;
                            end
                        end
                        idl_pkg::CMD_POP_FIRST, idl_pkg::CMD_POP_LAST: begin
                            if (empty) begin
                                n_status = idl_pkg::ST_EMPTY;
                            end else begin
                                // pop first runs as a remove at position 0
                                n_pos   = '0;
                                n_src   = (idl_pkg::t_cmd'(i_command) ==
                                           idl_pkg::CMD_POP_LAST) ? last_addr : '0;
                                n_state = S_FETCH;
                            end
                        end
                        idl_pkg::CMD_GET, idl_pkg::CMD_REMOVE: begin
                            if (empty) begin
                                n_status = idl_pkg::ST_EMPTY;
                            end else if (pos_ext >= cnt_ext) begin
                                n_status = idl_pkg::ST_RANGE;
                            end else begin
                                n_src   = ADDR_W'(i_position);
                                n_state = S_FETCH;
                            end
                        end
                        default: begin
                            // unused codes report only the list view
                        end
                    endcase
                end
            end
            S_FETCH: begin
                mem_re    = 1'b1;
                mem_raddr = r_src;
                n_state   = S_GRAB;
            end
            S_GRAB: begin
                n_val   = mem_rdata;
                n_found = 1'b1;
                unique case (r_cmd)
                    idl_pkg::CMD_POP_LAST: begin
                        n_count = r_count - CNT_W'(1);
                        n_state = S_PEEK0;
                    end
                    idl_pkg::CMD_POP_FIRST, idl_pkg::CMD_REMOVE: begin
                        // close the gap: entries above the position move down
                        n_src   = r_pos + ADDR_W'(1);
                        n_left  = r_count - CNT_W'(1) - CNT_W'(r_pos);
                        n_count = r_count - CNT_W'(1);
                        n_up    = 1'b0;
                        n_pend  = 1'b0;
                        n_state = S_SHIFT;
                    end
                    default: begin
                        n_state = S_PEEK0;
                    end
                endcase
            end
            S_SHIFT: begin
                // read one entry ahead while writing back the one read before
                if (r_left != '0) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_src;
                    n_src     = r_up ? (r_src - ADDR_W'(1)) : (r_src + ADDR_W'(1));
                    n_dst     = r_src;
                    n_left    = r_left - CNT_W'(1);
                    n_pend    = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_up ? (r_dst + ADDR_W'(1)) : (r_dst - ADDR_W'(1));
                    mem_wdata = mem_rdata;
                end
                // the last pending write lands in the same cycle
                if (r_left == '0) begin
                    n_state = r_up ? S_FRONT : S_PEEK0;
                end
            end
            S_FRONT: begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = r_word;
                n_count   = r_count + CNT_W'(1);
                n_state   = S_PEEK0;
            end
            S_PEEK0: begin
                if (empty) begin
                    // empty list: first and last read as zero
                    n_done     = 1'b1;
                    n_o_val    = idl_pkg::PORT_W'(r_val);
                    n_o_found  = r_found;
                    n_o_status = r_status;
                    n_o_count  = idl_pkg::COUNT_W'(r_count);
                    n_o_first  = '0;
                    n_o_last   = '0;
                    n_state    = S_IDLE;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = '0;
                    n_state   = S_PEEK1;
                end
            end
            S_PEEK1: begin
                n_first   = mem_rdata;
                mem_re    = 1'b1;
                mem_raddr = last_addr;
                n_state   = S_PEEK2;
            end
            S_PEEK2: begin
                n_done     = 1'b1;
                n_o_val    = idl_pkg::PORT_W'(r_val);
                n_o_found  = r_found;
                n_o_status = r_status;
                n_o_count  = idl_pkg::COUNT_W'(r_count);
                n_o_first  = idl_pkg::PORT_W'(r_first);
                n_o_last   = idl_pkg::PORT_W'(mem_rdata);
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
            r_done  <= n_done;
        end
    end

    // payload and working registers
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_word     <= n_word;
        r_pos      <= n_pos;
        r_src      <= n_src;
        r_dst      <= n_dst;
        r_left     <= n_left;
        r_up       <= n_up;
        r_val      <= n_val;
        r_found    <= n_found;
        r_status   <= n_status;
        r_first    <= n_first;
        r_o_val    <= n_o_val;
        r_o_found  <= n_o_found;
        r_o_status <= n_o_status;
        r_o_count  <= n_o_count;
        r_o_first  <= n_o_first;
        r_o_last   <= n_o_last;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_done         = r_done;
    assign o_result_value = r_o_val;
    assign o_found        = r_o_found;
    assign o_status       = r_o_status;
    assign o_entry_count  = r_o_count;
    assign o_first_value  = r_o_first;
    assign o_last_value   = r_o_last;

endmodule

// ===== design/idl_chk.sv =====
`timescale 1ns / 1ps
// port-level checks for the indexed deque list, bound to the top level
module idl_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        o_done,
    input logic                        o_found,
    input logic [idl_pkg::STAT_W-1:0]  o_status,
    input logic [idl_pkg::COUNT_W-1:0] o_entry_count
);

    // every accepted command makes the block busy in the following cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("command accepted but block not busy");

    // a result word comes out exactly when busy drops
    a_done_on_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $fell(busy))
        else $error("result word without end of command");

    a_fall_gives_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("command ended without a result word");

    // a returned entry never comes with an error status
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_found) |-> (o_status == idl_pkg::ST_OK))
        else $error("found with error status");

    // an empty list report leaves the count at zero
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == idl_pkg::ST_EMPTY) |-> (o_entry_count == '0))
        else $error("empty status with nonzero count");

endmodule

bind indexed_deque_list idl_chk u_idl_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_done        (o_done),
    .o_found       (o_found),
    .o_status      (o_status),
    .o_entry_count (o_entry_count)
);

// ===== tb/sv/indexed_deque_list_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the indexed deque list: predictor, driver, monitor, watchdog
module indexed_deque_list_tb;

    localparam int CAPACITY     = 256;
    localparam int STALL_LIMIT  = 2000;  // longest command plus the longest idle gap
    localparam int DRAIN_CYCLES = 300;   // quiet time after the last result
    localparam int TOTAL_ITEMS  = 550;   // directed words, fill, drain and a mixed tail

    // command codes the block leaves unused, must come back as a no-op
    localparam logic [idl_pkg::CMD_W-1:0] CMD_SPARE_A = 3'd6;
    localparam logic [idl_pkg::CMD_W-1:0] CMD_SPARE_B = 3'd7;

    // one command word as queued for the driver, with the idle gap ahead of it
    typedef struct packed {
        logic [idl_pkg::CMD_W-1:0]  command;
        logic [idl_pkg::PORT_W-1:0] value;
        logic [idl_pkg::POS_W-1:0]  position;
        logic [4:0]                 gap;
    } t_list_cmd;

    // one result word as the block reports it
    typedef struct packed {
        logic [idl_pkg::PORT_W-1:0]  value;
        logic                        found;
        idl_pkg::t_status            status;
        logic [idl_pkg::COUNT_W-1:0] count;
        logic [idl_pkg::PORT_W-1:0]  first;
        logic [idl_pkg::PORT_W-1:0]  last;
    } t_list_view;

    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          start         = 1'b0;
    logic [idl_pkg::CMD_W-1:0]     i_command     = '0;
    logic [idl_pkg::PORT_W-1:0]    i_entry_value = '0;
    logic [idl_pkg::POS_W-1:0]     i_position    = '0;
    logic                          busy;
    logic                          o_done;
    logic [idl_pkg::PORT_W-1:0]    o_result_value;
    logic                          o_found;
    logic [idl_pkg::STAT_W-1:0]    o_status;
    logic [idl_pkg::COUNT_W-1:0]   o_entry_count;
    logic [idl_pkg::PORT_W-1:0]    o_first_value;
    logic [idl_pkg::PORT_W-1:0]    o_last_value;

    t_list_cmd  pending_cmds[$];   // command words not yet handed to the block
    t_list_view expected_views[$]; // predicted result words, oldest first

    // predictor copy of the list
    logic [idl_pkg::PORT_W-1:0] list_mem [0:CAPACITY-1];
    int                         list_len = 0;

    // stimulus shaping state
    int gen_len      = 0;  // entry count as the generator sees it, used only to bias commands
    int stretch_left = 0;
    bit stretch_tight = 1'b0;

    int error_count  = 0;
    int results_seen = 0;
    int quiet_cycles = 0;
    int hold_off     = 0;

    indexed_deque_list #(
        .CAPACITY   (CAPACITY),
        .WORD_WIDTH (32)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_command      (i_command),
        .i_entry_value  (i_entry_value),
        .i_position     (i_position),
        .busy           (busy),
        .o_done         (o_done),
        .o_result_value (o_result_value),
        .o_found        (o_found),
        .o_status       (o_status),
        .o_entry_count  (o_entry_count),
        .o_first_value  (o_first_value),
        .o_last_value   (o_last_value)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // predictor: applies one accepted command to the list copy and queues
    // the result word it should produce
    // ------------------------------------------------------------------
    task automatic apply_list_command(input logic [idl_pkg::CMD_W-1:0] cmd,
                                      input logic [idl_pkg::PORT_W-1:0] word,
                                      input logic [idl_pkg::POS_W-1:0] pos);
        t_list_view v;
        int         i;
        v        = '0;
        v.status = idl_pkg::ST_OK;
        case (cmd)
            idl_pkg::CMD_ADD_BACK, idl_pkg::CMD_ADD_FRONT: begin
                if (list_len >= CAPACITY) begin
                    v.status = idl_pkg::ST_FULL;
                end else begin
                    if (cmd == idl_pkg::CMD_ADD_BACK) begin
                        list_mem[list_len] = word;
                    end else begin
                        // open a hole at position 0
                        for (i = list_len; i > 0; i--) list_mem[i] = list_mem[i-1];
                        list_mem[0] = word;
                    end
                    list_len++;
                end
            end
            idl_pkg::CMD_POP_FIRST: begin
                if (list_len == 0) begin
                    v.status = idl_pkg::ST_EMPTY;
                end else begin
                    v.value = list_mem[0];
                    v.found = 1'b1;
                    for (i = 0; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
                    list_len--;
                end
            end
            idl_pkg::CMD_POP_LAST: begin
                if (list_len == 0) begin
                    v.status = idl_pkg::ST_EMPTY;
                end else begin
                    list_len--;
                    v.value = list_mem[list_len];
                    v.found = 1'b1;
                end
            end
            idl_pkg::CMD_GET, idl_pkg::CMD_REMOVE: begin
                if (list_len == 0) begin
                    v.status = idl_pkg::ST_EMPTY;
                end else if (int'(pos) >= list_len) begin
                    v.status = idl_pkg::ST_RANGE;
                end else begin
                    v.value = list_mem[pos];
                    v.found = 1'b1;
                    if (cmd == idl_pkg::CMD_REMOVE) begin
                        // close the gap behind the removed entry
                        for (i = int'(pos); i + 1 < list_len; i++)
                            list_mem[i] = list_mem[i+1];
                        list_len--;
                    end
                end
            end
            default: begin
                // unused codes leave the list alone
            end
        endcase
        v.count = idl_pkg::COUNT_W'(list_len);
        v.first = (list_len != 0) ? list_mem[0] : '0;
        v.last  = (list_len != 0) ? list_mem[list_len-1] : '0;
        expected_views.push_back(v);
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // data words: mostly random, with the all-zero and all-one extremes mixed in
    function automatic logic [idl_pkg::PORT_W-1:0] rand_word();
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return $urandom;
    endfunction

    // positions: mostly inside the list, the rest anywhere in the 8-bit range
    function automatic logic [idl_pkg::POS_W-1:0] pick_pos(input int n);
        if (n > 0 && $urandom_range(0, 3) != 0)
            return idl_pkg::POS_W'($urandom_range(0, n - 1));
        return idl_pkg::POS_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [idl_pkg::CMD_W-1:0] pick_mixed();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 20) return idl_pkg::CMD_ADD_BACK;
        if (r < 35) return idl_pkg::CMD_ADD_FRONT;
        if (r < 47) return idl_pkg::CMD_POP_FIRST;
        if (r < 57) return idl_pkg::CMD_POP_LAST;
        if (r < 72) return idl_pkg::CMD_GET;
        if (r < 92) return idl_pkg::CMD_REMOVE;
        return ($urandom_range(0, 1) != 0) ? CMD_SPARE_A : CMD_SPARE_B;
    endfunction

    // queue one word; gaps come in stretches, some of them back to back
    task automatic queue_word(input logic [idl_pkg::CMD_W-1:0] cmd,
                              input logic [idl_pkg::PORT_W-1:0] word,
                              input logic [idl_pkg::POS_W-1:0] pos);
        t_list_cmd c;
        if (stretch_left == 0) begin
            stretch_left  = $urandom_range(15, 50);
            stretch_tight = ($urandom_range(0, 2) == 0);
        end
        stretch_left--;
        c.command  = cmd;
        c.value    = word;
        c.position = pos;
        c.gap      = stretch_tight ? 5'd0 : 5'($urandom_range(0, 17));
        pending_cmds.push_back(c);
        // rough count tracking so the random part can steer toward full and empty
        case (cmd)
            idl_pkg::CMD_ADD_BACK, idl_pkg::CMD_ADD_FRONT:
                if (gen_len < CAPACITY) gen_len++;
            idl_pkg::CMD_POP_FIRST, idl_pkg::CMD_POP_LAST:
                if (gen_len > 0) gen_len--;
            idl_pkg::CMD_REMOVE:
                if (gen_len > 0 && int'(pos) < gen_len) gen_len--;
            default: ;
        endcase
    endtask

    task automatic build_stimulus();
        int unsigned r;
        logic [idl_pkg::CMD_W-1:0] c;

        // directed: everything against an empty list first
        queue_word(idl_pkg::CMD_POP_FIRST, 32'h1234_5678, 8'd0);
        queue_word(idl_pkg::CMD_POP_LAST,  32'h0, 8'd255);
        queue_word(idl_pkg::CMD_GET,       32'h0, 8'd0);
        queue_word(idl_pkg::CMD_REMOVE,    32'h0, 8'd0);
        queue_word(CMD_SPARE_A,            32'hFFFF_FFFF, 8'd255);
        queue_word(CMD_SPARE_B,            32'h0, 8'd0);
        // value extremes at the back, alternating bit patterns at the front
        queue_word(idl_pkg::CMD_ADD_BACK,  32'h0000_0000, 8'd255);
        queue_word(idl_pkg::CMD_ADD_BACK,  32'hFFFF_FFFF, 8'd0);
        queue_word(idl_pkg::CMD_ADD_FRONT, 32'hA5A5_A5A5, 8'd0);
        queue_word(idl_pkg::CMD_ADD_FRONT, 32'h5A5A_5A5A, 8'd255);
        // get: first, last, just past the end, far past the end
        queue_word(idl_pkg::CMD_GET,       32'h0, 8'd0);
        queue_word(idl_pkg::CMD_GET,       32'h0, 8'd3);
        queue_word(idl_pkg::CMD_GET,       32'h0, 8'd4);
        queue_word(idl_pkg::CMD_GET,       32'h0, 8'd255);
        // remove: out of range, middle, then the final entry
        queue_word(idl_pkg::CMD_REMOVE,    32'h0, 8'd255);
        queue_word(idl_pkg::CMD_REMOVE,    32'h0, 8'd1);
        queue_word(idl_pkg::CMD_REMOVE,    32'h0, 8'd2);
        queue_word(CMD_SPARE_A,            32'h0, 8'd1);
        queue_word(CMD_SPARE_B,            32'hFFFF_FFFF, 8'd0);
        queue_word(idl_pkg::CMD_POP_LAST,  32'h0, 8'd0);
        queue_word(idl_pkg::CMD_POP_FIRST, 32'h0, 8'd0);
        queue_word(idl_pkg::CMD_POP_FIRST, 32'h0, 8'd0);

        // random: short mixed warm-up near empty
        repeat (20) queue_word(pick_mixed(), rand_word(), pick_pos(gen_len));

        // fill to capacity, almost all adds from both ends
        while (gen_len < CAPACITY) begin
            r = $urandom_range(0, 99);
            if (r < 48)      c = idl_pkg::CMD_ADD_BACK;
            else if (r < 96) c = idl_pkg::CMD_ADD_FRONT;
            else if (r < 98) c = idl_pkg::CMD_GET;
            else             c = ($urandom_range(0, 1) != 0) ? CMD_SPARE_A : CMD_SPARE_B;
            queue_word(c, rand_word(), pick_pos(gen_len));
        end

        // full list: adds are refused, every position up to 255 is valid
        repeat (4) queue_word(idl_pkg::CMD_ADD_BACK, rand_word(), pick_pos(gen_len));
        repeat (4) queue_word(idl_pkg::CMD_ADD_FRONT, rand_word(), pick_pos(gen_len));
        repeat (6) queue_word(idl_pkg::CMD_GET, rand_word(),
                              idl_pkg::POS_W'($urandom_range(0, 255)));
        queue_word(idl_pkg::CMD_REMOVE, rand_word(), 8'd255);
        queue_word(idl_pkg::CMD_REMOVE, rand_word(), idl_pkg::POS_W'($urandom_range(0, 254)));

        // drain back to empty
        while (gen_len > 0) begin
            r = $urandom_range(0, 99);
            if (r < 40)      c = idl_pkg::CMD_POP_FIRST;
            else if (r < 80) c = idl_pkg::CMD_POP_LAST;
            else if (r < 97) c = idl_pkg::CMD_REMOVE;
            else             c = idl_pkg::CMD_GET;
            queue_word(c, rand_word(), pick_pos(gen_len));
        end

        // mixed tail, if the fill and drain left room
        while (pending_cmds.size() < TOTAL_ITEMS)
            queue_word(pick_mixed(), rand_word(), pick_pos(gen_len));
    endtask

    // ------------------------------------------------------------------
    // driver: presents queued words, start held high across back-to-back words
    // ------------------------------------------------------------------
    task automatic present_next();
        t_list_cmd c;
        c = pending_cmds.pop_front();
        i_command     <= c.command;
        i_entry_value <= c.value;
        i_position    <= c.position;
        start         <= 1'b1;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start    <= 1'b0;
            hold_off <= 0;
        end else if (start && !busy) begin
            // word taken at this edge; port values are still the accepted ones
            apply_list_command(i_command, i_entry_value, i_position);
            if (pending_cmds.size() == 0) begin
                start <= 1'b0;
            end else if (pending_cmds[0].gap == 0) begin
                present_next();
            end else begin
                start    <= 1'b0;
                hold_off <= int'(pending_cmds[0].gap) - 1;
            end
        end else if (!start) begin
            if (hold_off != 0) begin
                hold_off <= hold_off - 1;
            end else if (pending_cmds.size() != 0) begin
                present_next();
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: every o_done word is compared with the oldest prediction
    // ------------------------------------------------------------------
    task automatic flag_error(input string what, input logic [idl_pkg::PORT_W-1:0] got,
                              input logic [idl_pkg::PORT_W-1:0] want);
        $display("mismatch on result %0d: %s got %h want %h", results_seen, what, got, want);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        t_list_view want;
        if (i_rst_n && o_done) begin
            if (expected_views.size() == 0) begin
                flag_error("unrequested result, value", o_result_value, '0);
            end else begin
                want = expected_views.pop_front();
                if (o_result_value !== want.value)
                    flag_error("result_value", o_result_value, want.value);
                if (o_found !== want.found)
                    flag_error("found", 32'(o_found), 32'(want.found));
                if (o_status !== want.status)
                    flag_error("status", 32'(o_status), 32'(want.status));
                if (o_entry_count !== want.count)
                    flag_error("entry_count", 32'(o_entry_count), 32'(want.count));
                if (o_first_value !== want.first)
                    flag_error("first_value", o_first_value, want.first);
                if (o_last_value !== want.last)
                    flag_error("last_value", o_last_value, want.last);
            end
            results_seen++;
        end
    end

    // ------------------------------------------------------------------
    // watchdog: no word moving in either direction for too long
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else if ((start && !busy) || o_done) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // run control: queue all words, release reset, wait for the last result
    // ------------------------------------------------------------------
    initial begin
        build_stimulus();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_cmds.size() != 0 || start || expected_views.size() != 0)
            @(posedge i_clk);
        // catch any stray result after the last expected one
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
